FILE: rtl/core/tap_tempo_estimator_macros.svh
// Assertion macros for the tap tempo estimator core.
// Needs no other file; included by modules that carry assertions.
`ifndef TAP_TEMPO_ESTIMATOR_MACROS_SVH
`define TAP_TEMPO_ESTIMATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked property, switched off while reset is high.
`define TTE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked property that must also hold during reset.
`define TTE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTE_ASSERT(label, clk, rst, prop, msg)
`define TTE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: rtl/core/tte_pkg.sv
// Shared constants and types of the tap tempo estimator.
// No dependencies; imported by the interfaces and the core.
package tte_pkg;

   localparam int HISTORY_DEPTH = 4;

   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 12;
   localparam int TEMPO_W    = 24;
   localparam int DEBOUNCE_W = 16;
   localparam int TIMEOUT_W  = 16;

   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   // weight total n(n+1)/2 at full history
   localparam int     WTOTAL_MAX    = HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2;
   localparam longint INTERVAL_MAX  = 4095;
   localparam longint MS_PER_MIN_Q8 = 15360000;
   localparam int     SUM_W         = $clog2(WTOTAL_MAX * INTERVAL_MAX + 1);
   localparam int     NUM_W         = $clog2(MS_PER_MIN_Q8 * WTOTAL_MAX + 1);
   localparam int     DIV_CNT_W     = $clog2(NUM_W);

   localparam logic [TEMPO_W-1:0] TEMPO_RESET_Q8 = 24'd30720;
   localparam logic [TEMPO_W-1:0] TEMPO_MAX_Q8   = 24'd15360000;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 16'd2000;
   localparam logic [INTERVAL_W-1:0] MIN_INT_RESET  = 12'd200;
   localparam logic [INTERVAL_W-1:0] MAX_INT_RESET  = 12'd2000;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE     = 2'd0,
      CSR_TIMEOUT      = 2'd1,
      CSR_MIN_INTERVAL = 2'd2,
      CSR_MAX_INTERVAL = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EVAL = 5'b00010,
      ST_SUM  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } fsm_state_type;

endpackage

FILE: rtl/core/tte_ifs.sv
// Channel interfaces of the tap tempo estimator: tap, result and CSR write.
// Depends on tte_pkg for field widths.
interface tte_req_if import tte_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] tap_time_ms;
   modport source (output valid, output tap_time_ms, input ready);
   modport sink   (input valid, input tap_time_ms, output ready);
endinterface

interface tte_rsp_if import tte_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               tempo_updated;
   logic [TEMPO_W-1:0] tempo_q8;
   modport source (output valid, output tempo_updated, output tempo_q8, input ready);
   modport sink   (input valid, input tempo_updated, input tempo_q8, output ready);
endinterface

interface tte_csr_if import tte_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/tap_tempo_estimator.sv
// Channel   Dir  Payload                          Transfer when
// req_if    in   tap_time_ms[31:0]                valid && ready
// rsp_if    out  tempo_updated, tempo_q8[23:0]    valid && ready
// csr_if    in   index[1:0], data[15:0]           valid && ready (ready tied high)
//
// Flow: a tap taken into a new interval goes through evaluation, the weighted sum, the divider
// and the done state to the result register: the weighted sum walks the intervals in use
// (1..4) one entry a cycle and the divider resolves one quotient bit a cycle. Ignored and
// restarting taps go from evaluation to the done state. req_if.ready is high only between taps.
// Reset: synchronous, active high; only config, history, tempo, state and result valid are reset.
// Stalls: the result register holds until taken; the next tap may be accepted meanwhile
// and its result waits in the done state until the register frees.
//
// Depends on tte_pkg, tte_ifs and tap_tempo_estimator_macros.svh.
`include "tap_tempo_estimator_macros.svh"

module tap_tempo_estimator import tte_pkg::*; (
   input logic        clock,
   input logic        reset,
   tte_req_if.sink    req_if,
   tte_rsp_if.source  rsp_if,
   tte_csr_if.sink    csr_if
);

   // configuration
   logic [DEBOUNCE_W-1:0] debounce_ff, debounce_in;
   logic [TIMEOUT_W-1:0]  timeout_ff, timeout_in;
   logic [INTERVAL_W-1:0] min_int_ff, min_int_in;
   logic [INTERVAL_W-1:0] max_int_ff, max_int_in;

   // estimator state
   logic [TIME_W-1:0]     prev_ff, prev_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [INTERVAL_W-1:0] hist_ff [HISTORY_DEPTH];
   logic [INTERVAL_W-1:0] hist_in [HISTORY_DEPTH];
   logic [TEMPO_W-1:0]    tempo_ff, tempo_in;

   // sequencer and datapath
   fsm_state_type         state_ff, state_in;
   logic [TIME_W-1:0]     tap_ff, tap_in;
   logic                  upd_ff, upd_in;
   logic [IDX_W-1:0]      k_ff, k_in;
   logic [SUM_W-1:0]      psum_ff, psum_in;   // running prefix sum of intervals
   logic [SUM_W-1:0]      wsum_ff, wsum_in;   // weighted sum, the divisor
   logic [NUM_W-1:0]      nstep_ff, nstep_in; // 60000*256*(k+1)
   logic [NUM_W-1:0]      num_ff, num_in;     // numerator, shifted out as quotient comes in
   logic [SUM_W-1:0]      rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  bit_ff, bit_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_upd_ff, rsp_upd_in;
   logic [TEMPO_W-1:0]    rsp_tempo_ff, rsp_tempo_in;

   // evaluation of one tap
   logic [TIME_W-1:0]     delta;
   logic                  no_prev, tap_ignore, tap_restart;
   // divider step
   logic [SUM_W:0]        trial;
   logic [SUM_W:0]        trial_diff;
   logic                  trial_ge;
   logic [NUM_W-1:0]      quot;
   logic [CNT_W-1:0]      k_next_cnt;
   logic [SUM_W-1:0]      psum_next;
   logic [NUM_W-1:0]      nstep_next;

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign csr_if.ready        = 1'b1;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.tempo_updated = rsp_upd_ff;
   assign rsp_if.tempo_q8     = rsp_tempo_ff;

   // wrapping difference; a stored time of zero means no tap seen
   assign delta       = tap_ff - prev_ff;
   assign no_prev     = (prev_ff == '0);
   assign tap_ignore  = !no_prev && (delta < TIME_W'(debounce_ff));
   assign tap_restart = no_prev || (delta > TIME_W'(timeout_ff)) ||
                        (delta < TIME_W'(min_int_ff)) || (delta > TIME_W'(max_int_ff));

   // sum S = sum over k of prefix sums, which gives weight n-i to entry i
   assign psum_next  = psum_ff + SUM_W'(hist_ff[k_ff]);
   assign nstep_next = nstep_ff + NUM_W'(MS_PER_MIN_Q8);
   assign k_next_cnt = CNT_W'(k_ff) + CNT_W'(1);

   // restoring division, one quotient bit a cycle
   assign trial      = {rem_ff, num_ff[NUM_W-1]};
   assign trial_ge   = (trial >= {1'b0, wsum_ff});
   assign trial_diff = trial - {1'b0, wsum_ff};
   assign quot       = {num_ff[NUM_W-2:0], trial_ge};

   always_comb begin
      debounce_in  = debounce_ff;
      timeout_in   = timeout_ff;
      min_int_in   = min_int_ff;
      max_int_in   = max_int_ff;
      prev_in      = prev_ff;
      count_in     = count_ff;
      hist_in      = hist_ff;
      tempo_in     = tempo_ff;
      state_in     = state_ff;
      tap_in       = tap_ff;
      upd_in       = upd_ff;
      k_in         = k_ff;
      psum_in      = psum_ff;
      wsum_in      = wsum_ff;
      nstep_in     = nstep_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_upd_in   = rsp_upd_ff;
      rsp_tempo_in = rsp_tempo_ff;

      if (csr_if.valid) begin
         case (csr_index_type'(csr_if.index))
            CSR_DEBOUNCE:     debounce_in = csr_if.data[DEBOUNCE_W-1:0];
            CSR_TIMEOUT:      timeout_in  = csr_if.data[TIMEOUT_W-1:0];
            CSR_MIN_INTERVAL: min_int_in  = csr_if.data[INTERVAL_W-1:0];
            CSR_MAX_INTERVAL: max_int_in  = csr_if.data[INTERVAL_W-1:0];
            default: ;
         endcase
      end

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               tap_in   = req_if.tap_time_ms;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            upd_in = 1'b0;
            if (tap_ignore) begin
               state_in = ST_DONE;
            end else if (tap_restart) begin
               // history entries stay but fall out of use
               count_in = '0;
               prev_in  = tap_ff;
               state_in = ST_DONE;
            end else begin
               prev_in = tap_ff;
               for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                  hist_in[i] = hist_ff[i-1];
               end
               hist_in[0] = delta[INTERVAL_W-1:0];
               if (count_ff < CNT_W'(HISTORY_DEPTH)) begin
                  count_in = count_ff + CNT_W'(1);
               end
               upd_in   = 1'b1;
               k_in     = '0;
               psum_in  = '0;
               wsum_in  = '0;
               nstep_in = '0;
               num_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            psum_in  = psum_next;
            wsum_in  = wsum_ff + psum_next;
            nstep_in = nstep_next;
            num_in   = num_ff + nstep_next;
            if (k_next_cnt == count_ff) begin
               rem_in   = '0;
               bit_in   = DIV_CNT_W'(NUM_W - 1);
               state_in = ST_DIV;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
            num_in = quot;
            bit_in = bit_ff - DIV_CNT_W'(1);
            if (bit_ff == '0) begin
               // zero divisor yields all ones and lands here too
               tempo_in = (quot > NUM_W'(TEMPO_MAX_Q8)) ? TEMPO_MAX_Q8 : quot[TEMPO_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_upd_in   = upd_ff;
               rsp_tempo_in = tempo_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         min_int_ff   <= MIN_INT_RESET;
         max_int_ff   <= MAX_INT_RESET;
         prev_ff      <= '0;
         count_ff     <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         tempo_ff     <= TEMPO_RESET_Q8;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         debounce_ff  <= debounce_in;
         timeout_ff   <= timeout_in;
         min_int_ff   <= min_int_in;
         max_int_ff   <= max_int_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         hist_ff      <= hist_in;
         tempo_ff     <= tempo_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tap_ff       <= tap_in;
      upd_ff       <= upd_in;
      k_ff         <= k_in;
      psum_ff      <= psum_in;
      wsum_ff      <= wsum_in;
      nstep_ff     <= nstep_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      bit_ff       <= bit_in;
      rsp_upd_ff   <= rsp_upd_in;
      rsp_tempo_ff <= rsp_tempo_in;
   end

   `TTE_ASSERT(a_tap_to_eval, clock, reset, (req_if.valid && req_if.ready) |=> (state_ff == ST_EVAL), "accepted tap did not move to evaluation")
   `TTE_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(HISTORY_DEPTH), "interval count beyond history depth")
   `TTE_ASSERT(a_rem_below_div, clock, reset, ((state_ff == ST_DIV) && (wsum_ff != '0)) |-> (rem_ff < wsum_ff), "divider remainder not below divisor")
   `TTE_ASSERT(a_tempo_bound, clock, reset, rsp_valid_ff |-> (rsp_tempo_ff <= TEMPO_MAX_Q8), "result tempo above saturation value")

endmodule

FILE: dv/tap_tempo_estimator_tb.sv
// Self-checking bench for tap_tempo_estimator: taps go in over req_if, every result is checked
// against a hand-written value or an untimed tempo tracker. CSR settings change between phases.
// Needs tte_pkg, tte_ifs and the core RTL.
module tap_tempo_estimator_tb import tte_pkg::*; ();

   localparam int RESET_CYCLES    = 9;
   localparam int SETTLE_CYCLES   = 40;    // covers the longest tap end to end
   localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall, fills the core
   localparam int STALL_LIMIT     = 5000;  // cycles with no transfer before giving up
   localparam int PHASES          = 8;
   localparam int PHASE_TAPS      = 140;   // random taps offered per phase

   typedef struct packed {
      logic               updated;
      logic [TEMPO_W-1:0] tempo_q8;
   } tempo_report_type;

   // One directed tap; 'typed' rows carry a hand-written result, the rest use the tracker.
   typedef struct packed {
      logic [TIME_W-1:0] tap_ms;
      logic              typed;
      tempo_report_type  want;
   } tap_row_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] guard;
      logic [CSR_DATA_W-1:0] gap_limit;
      logic [CSR_DATA_W-1:0] shortest;
      logic [CSR_DATA_W-1:0] longest;
   } csr_set_type;

   // How the result side takes transfers in a phase.
   typedef enum int {
      SINK_ALWAYS  = 0,
      SINK_COIN    = 1,
      SINK_PATTERN = 2,
      SINK_SPARSE  = 3
   } sink_pace_type;

   logic clock;
   logic reset;

   tte_req_if req_if ();
   tte_rsp_if rsp_if ();
   tte_csr_if csr_if ();

   tap_tempo_estimator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // ---------------------------------------------------------------------------------------
   // Tempo tracker: settings, interval history and current estimate, kept in step with
   // every accepted tap and CSR write.
   // ---------------------------------------------------------------------------------------
   logic [DEBOUNCE_W-1:0] guard_ms;
   logic [TIMEOUT_W-1:0]  gap_limit_ms;
   logic [INTERVAL_W-1:0] shortest_ms;
   logic [INTERVAL_W-1:0] longest_ms;
   logic [INTERVAL_W-1:0] beat_hist [HISTORY_DEPTH];   // entry 0 newest
   logic [TIME_W-1:0]     last_tap_ms;                 // 0 means no tap yet
   int unsigned           beats_held;
   logic [TEMPO_W-1:0]    tempo_now;

   tempo_report_type pending_tempos [$];
   int unsigned      faults = 0;
   int unsigned      idle_cycles = 0;

   // sender and receiver pacing
   bit               tap_offered = 1'b0;
   bit               sender_gaps = 1'b1;
   int unsigned      burst_left = 0;
   int unsigned      hold_off_asked = 0;     // bumped by the sender side
   int unsigned      hold_off_taken = 0;     // caught up by the receiver
   sink_pace_type    sink_pace = SINK_ALWAYS;
   logic [15:0]      stall_seed = 16'hA5F3;  // stall pattern, set per phase
   logic [3:0]       stall_step = '0;        // receiver's position in the pattern

   function automatic void clear_tracker();
      guard_ms     = DEBOUNCE_RESET;
      gap_limit_ms = TIMEOUT_RESET;
      shortest_ms  = MIN_INT_RESET;
      longest_ms   = MAX_INT_RESET;
      for (int i = 0; i < HISTORY_DEPTH; i++)
         beat_hist[i] = '0;
      last_tap_ms = '0;
      beats_held  = 0;
      tempo_now   = TEMPO_RESET_Q8;
   endfunction

   // Bits above a register's width are dropped.
   function automatic void latch_setting(input csr_index_type idx,
                                         input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_DEBOUNCE:     guard_ms     = value[DEBOUNCE_W-1:0];
         CSR_TIMEOUT:      gap_limit_ms = value[TIMEOUT_W-1:0];
         CSR_MIN_INTERVAL: shortest_ms  = value[INTERVAL_W-1:0];
         CSR_MAX_INTERVAL: longest_ms   = value[INTERVAL_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic tempo_report_type track_tap(input logic [TIME_W-1:0] now_ms);
      logic [TIME_W-1:0] delta;
      longint unsigned   wsum;
      longint unsigned   wtotal;
      longint unsigned   weight;
      longint unsigned   q;
      tempo_report_type  report;
      delta          = now_ms - last_tap_ms;   // wraps modulo 2^32
      report.updated = 1'b0;
      if (last_tap_ms != 0 && delta < guard_ms) begin
         // debounced, nothing changes
      end else if (last_tap_ms == 0 || delta > gap_limit_ms ||
                   delta < shortest_ms || delta > longest_ms) begin
         // first tap, timeout or interval out of range: restart, tempo kept
         beats_held  = 0;
         last_tap_ms = now_ms;
      end else begin
         last_tap_ms = now_ms;
         for (int i = HISTORY_DEPTH - 1; i > 0; i--)
            beat_hist[i] = beat_hist[i-1];
         beat_hist[0] = delta[INTERVAL_W-1:0];
         if (beats_held < HISTORY_DEPTH)
            beats_held++;
         // newest interval weighs most: weight n - i for entry i
         wsum   = 0;
         wtotal = 0;
         for (int i = 0; i < beats_held; i++) begin
            weight = beats_held - i;
            wsum   += beat_hist[i] * weight;
            wtotal += weight;
         end
         if (wsum == 0) begin
            tempo_now = TEMPO_MAX_Q8;
         end else begin
            q         = (MS_PER_MIN_Q8 * wtotal) / wsum;
            tempo_now = (q > TEMPO_MAX_Q8) ? TEMPO_MAX_Q8 : q[TEMPO_W-1:0];
         end
         report.updated = 1'b1;
      end
      report.tempo_q8 = tempo_now;
      return report;
   endfunction

   // Gap to the next tap, biased towards well-formed intervals under the current settings.
   function automatic logic [TIME_W-1:0] pick_gap_ms();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 60 && shortest_ms <= longest_ms) begin
         case ($urandom_range(9))
            0:       return TIME_W'(shortest_ms);
            1:       return TIME_W'(longest_ms);
            default: return $urandom_range(longest_ms, shortest_ms);
         endcase
      end
      if (sel < 70)
         return $urandom_range(guard_ms);            // at or inside debounce
      if (sel < 78)
         return gap_limit_ms + $urandom_range(2);    // at the timeout edge or just past it
      if (sel < 86)
         return $urandom_range(4200);
      if (sel < 94)
         return $urandom_range(3);                   // tiny intervals, zero included
      return $urandom();
   endfunction

   // ---------------------------------------------------------------------------------------
   // Clock and drivers
   // ---------------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      latch_setting(idx, value);
   endtask

   // Leaves valid high; the caller lowers it only when a gap follows.
   task automatic offer_tap(input logic [TIME_W-1:0] tap_ms, input logic typed,
                            input tempo_report_type want);
      tempo_report_type seen;
      req_if.valid       <= 1'b1;
      req_if.tap_time_ms <= tap_ms;
      tap_offered = 1'b1;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      seen = track_tap(tap_ms);
      pending_tempos.push_back(typed ? want : seen);
   endtask

   // Bursts of random length, random gaps between them when sender gaps are on.
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         if (sender_gaps) begin
            gap = $urandom_range(15, 1);
            req_if.valid <= 1'b0;
            tap_offered = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Sender pauses until every result is back, then lets the core settle.
   task automatic drain_results();
      if (tap_offered) begin
         req_if.valid <= 1'b0;
         tap_offered = 1'b0;
      end
      while (pending_tempos.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Receiver: own stall pattern per phase, plus a long hold-off on request.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_taken != hold_off_asked) begin
            hold_off_taken = hold_off_asked;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         stall_step = stall_step + 4'd1;
         case (sink_pace)
            SINK_ALWAYS:  rsp_if.ready <= 1'b1;
            SINK_COIN:    rsp_if.ready <= 1'($urandom_range(1));
            SINK_PATTERN: rsp_if.ready <= stall_seed[stall_step];
            default:      rsp_if.ready <= ($urandom_range(7) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result check: every result transfer against the oldest pending expectation
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      tempo_report_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_tempos.size() == 0) begin
            $display("%0t: result with nothing pending: updated %0b tempo %0d", $time,
                     rsp_if.tempo_updated, rsp_if.tempo_q8);
            faults++;
         end else begin
            want = pending_tempos.pop_front();
            if (rsp_if.tempo_updated !== want.updated) begin
               $display("%0t: tempo_updated expected %0b got %0b", $time,
                        want.updated, rsp_if.tempo_updated);
               faults++;
            end
            if (rsp_if.tempo_q8 !== want.tempo_q8) begin
               $display("%0t: tempo_q8 expected %0d got %0d", $time,
                        want.tempo_q8, rsp_if.tempo_q8);
               faults++;
            end
         end
      end
   end

   // Watchdog: any transfer on any channel counts as progress.
   always @(posedge clock) begin : watchdog
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
          (csr_if.valid === 1'b1 && csr_if.ready === 1'b1))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("tap_tempo_estimator: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      tap_row_type       directed_taps [0:20];
      csr_set_type       phase_csr [1:PHASES-1];
      logic [TIME_W-1:0] tap_clock_ms;
      logic [TIME_W-1:0] tap_ms;
      int unsigned       taps_sent;

      // Directed taps under the reset settings (debounce 50, timeout 2000, range 200..2000).
      directed_taps = '{
         '{32'd0,          1'b1, '{1'b0, TEMPO_RESET_Q8}},  // tap at time zero, kept as no tap
         '{32'd1000,       1'b1, '{1'b0, TEMPO_RESET_Q8}},  // first tap only stores its time
         '{32'd1010,       1'b1, '{1'b0, TEMPO_RESET_Q8}},  // debounced
         '{32'd1510,       1'b0, '0},                       // first interval, 510 ms
         '{32'd2010,       1'b0, '0},
         '{32'd2510,       1'b0, '0},
         '{32'd3010,       1'b0, '0},                       // history full
         '{32'd3510,       1'b0, '0},                       // count stays at four
         '{32'd3710,       1'b0, '0},                       // shortest interval exactly
         '{32'd5710,       1'b0, '0},                       // longest interval, timeout exactly
         '{32'd7711,       1'b0, '0},                       // one past the timeout: restart
         '{32'd7910,       1'b0, '0},                       // 199 ms, below range: restart
         '{32'd7959,       1'b0, '0},                       // 49 ms, debounced
         '{32'd7960,       1'b0, '0},                       // 50 ms, past debounce, below range
         '{32'hFFFF_FF00,  1'b0, '0},                       // huge gap: restart
         '{32'h0000_00F4,  1'b0, '0},                       // 500 ms across the wrap
         '{32'hFFFF_FFFF,  1'b0, '0},                       // all ones: restart
         '{32'h0000_01F3,  1'b0, '0},                       // 500 ms across the wrap again
         '{32'd0,          1'b0, '0},                       // back to zero: restart at no tap
         '{32'd500,        1'b0, '0},                       // so this is a first tap again
         '{32'd1000,       1'b0, '0}
      };

      // Upper data bits on the 12-bit registers must be dropped by the core.
      phase_csr = '{
         '{16'd0,     16'hFFFF, 16'hF001, 16'h0FFF},   // widest window
         '{16'd0,     16'hFFFF, 16'h0000, 16'h1FFF},   // zero intervals: tempo saturates
         '{16'hFFFF,  16'hFFFF, 16'h0FFF, 16'h0FFF},   // maxima everywhere
         '{16'd0,     16'd0,    16'd1,    16'd1},      // zero timeout
         '{16'd10,    16'd3000, 16'd100,  16'd300},
         '{16'd30,    16'd1500, 16'd1000, 16'd500},    // empty window: every tap past debounce restarts
         '{16'd40,    16'd800,  16'hA0FA, 16'h52BC}
      };

      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.tap_time_ms <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= CSR_DEBOUNCE;
      csr_if.data        <= '0;
      clear_tracker();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_taps[r]) begin
         offer_tap(directed_taps[r].tap_ms, directed_taps[r].typed, directed_taps[r].want);
         pace_sender();
      end
      tap_clock_ms = directed_taps[20].tap_ms;

      for (int phase = 0; phase < PHASES; phase++) begin
         // settings only change with the core idle
         if (phase != 0) begin
            drain_results();
            write_register(CSR_DEBOUNCE,     phase_csr[phase].guard);
            write_register(CSR_TIMEOUT,      phase_csr[phase].gap_limit);
            write_register(CSR_MIN_INTERVAL, phase_csr[phase].shortest);
            write_register(CSR_MAX_INTERVAL, phase_csr[phase].longest);
            csr_if.valid <= 1'b0;
         end
         sink_pace   = sink_pace_type'(phase % 4);
         stall_seed  = 16'($urandom()) | 16'h0001;
         sender_gaps = (phase % 3 != 1);   // phase 4: no idling on either side
         taps_sent   = 0;
         while (taps_sent < PHASE_TAPS) begin
            if ((phase == 2 || phase == 6) && taps_sent == 40)
               hold_off_asked++;
            if ($urandom_range(49) == 0)
               tap_ms = ($urandom_range(3) == 0) ? '0 : $urandom();
            else
               tap_ms = tap_clock_ms + pick_gap_ms();
            tap_clock_ms = tap_ms;
            offer_tap(tap_ms, 1'b0, '0);
            taps_sent++;
            pace_sender();
         end
      end

      drain_results();
      if (faults == 0 && pending_tempos.size() == 0)
         $display("tap_tempo_estimator: match");
      else
         $display("tap_tempo_estimator: mismatch");
      $finish;
   end

endmodule
